/* sv/hsle_pkg.sv */
// ----------------------------------------------------------------------------
// Link engine package
// Shared widths, action and status codes, frame positions and a parity helper for the
// half-duplex serial link engine.
// ----------------------------------------------------------------------------
package hsle_pkg;

  // Field widths.
  localparam int unsigned ActionW  = 2;
  localparam int unsigned DataBits = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned IndexW   = 4;
  localparam int unsigned FrameW   = 11;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // Action codes carried in the input tuser.
  localparam logic [ActionW-1:0] ActTick    = 2'd0;
  localparam logic [ActionW-1:0] ActSend    = 2'd1;
  localparam logic [ActionW-1:0] ActReceive = 2'd2;

  // Status codes.
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StLineHigh  = 3'd1;
  localparam logic [StatusW-1:0] StNack      = 3'd2;
  localparam logic [StatusW-1:0] StBadStop   = 3'd3;
  localparam logic [StatusW-1:0] StBadParity = 3'd4;
  localparam logic [StatusW-1:0] StBadStart  = 3'd5;
  localparam logic [StatusW-1:0] StQueueFull = 3'd6;

  // Bit positions of the receive and send sequences.
  localparam logic [IndexW-1:0] PosRxStop  = 4'd10;
  localparam logic [IndexW-1:0] PosRxAck   = 4'd11;
  localparam logic [IndexW-1:0] PosRxEnd   = 4'd12;
  localparam logic [IndexW-1:0] PosTxWait  = 4'd11;
  localparam logic [IndexW-1:0] PosTxFinal = 4'd12;
  localparam logic [IndexW-1:0] PosTxSwap  = 4'd13;

  // One result item.
  typedef struct packed {
    logic                line_out;
    logic                tx_busy;
    logic                rx_busy;
    logic                tx_started;
    logic                tx_done;
    logic [StatusW-1:0]  status;
    logic [DataBits-1:0] rx_byte;
    logic                rx_valid;
  } result_t;

  // Even parity bit of a data byte: one when the count of set bits is odd.
  function automatic logic odd_count(input logic [DataBits-1:0] v);
    return ^v;
  endfunction

endpackage

/* sv/handshake_serial_link_engine_top.sv */
// ----------------------------------------------------------------------------
// Handshake serial link engine
// Half-duplex one-wire-each-way link: sends an 11-bit frame and samples the
// partner's ACK, or receives and checks a frame and drives the ACK.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  ----------------------------------------------------
//  s_axis    in         one bit interval: action, tx_byte, line_in, rx_room
//  m_axis    out        one result per input transfer: line level and status
//
//  Each input transfer is handled combinationally: the next state and the result
//  are formed from the state registers and the input, and the result lands in
//  the output register on the accepting edge. One transfer per cycle is
//  sustained; s_axis_tready_o drops only while the output register is full
//  and m_axis_tready_i is low. Reset leaves the line driven high and idle.

module handshake_serial_link_engine_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] tx_byte, [8] line_in, [9] rx_room, [15:10] zero
  input  logic [hsle_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [hsle_pkg::ActionW-1:0]  s_axis_tuser_i,
  // Result item.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] line_out, [1] tx_busy, [2] rx_busy, [3] tx_started, [4] tx_done,
  // [7:5] status, [15:8] rx_byte, [16] rx_valid, [23:17] zero
  output logic [hsle_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Engine state.
  logic [hsle_pkg::IndexW-1:0]  bit_index_q, bit_index_d;
  logic [hsle_pkg::FrameW-1:0]  shift_frame_q, shift_frame_d;
  logic [hsle_pkg::StatusW-1:0] error_code_q, error_code_d;
  logic                         ack_level_q, ack_level_d;
  logic                         sending_q, sending_d;
  logic                         receiving_q, receiving_d;
  logic                         drive_level_q, drive_level_d;

  // Output register.
  logic                         out_valid_q;
  hsle_pkg::result_t            out_q, out_d;

  // Unpacked input fields.
  logic [hsle_pkg::ActionW-1:0]  action;
  logic [hsle_pkg::DataBits-1:0] tx_byte;
  logic                          line_in;
  logic                          rx_room;
  logic                          in_xfer;

  // Receive decode helpers.
  logic [hsle_pkg::FrameW-1:0]   rx_frame;
  logic [hsle_pkg::DataBits-1:0] rx_data;

  assign action  = s_axis_tuser_i;
  assign tx_byte = s_axis_tdata_i[7:0];
  assign line_in = s_axis_tdata_i[8];
  assign rx_room = s_axis_tdata_i[9];

  // The output register takes a new result when empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Frame after shifting in the current sample; data bits reversed to a byte.
  assign rx_frame = {shift_frame_q[hsle_pkg::FrameW-2:0], line_in};
  always_comb begin
    for (int i = 0; i < hsle_pkg::DataBits; i++) begin
      rx_data[i] = rx_frame[9-i];
    end
  end

  // Next state and result for one bit interval.
  always_comb begin
    bit_index_d   = bit_index_q;
    shift_frame_d = shift_frame_q;
    error_code_d  = error_code_q;
    ack_level_d   = ack_level_q;
    sending_d     = sending_q;
    receiving_d   = receiving_q;
    drive_level_d = drive_level_q;
    out_d         = '0;

    case (action)
      hsle_pkg::ActSend: begin
        if (!sending_q && !receiving_q && line_in) begin
          sending_d        = 1'b1;
          out_d.tx_started = 1'b1;
          drive_level_d    = 1'b0;
          // Remaining frame: data LSB first, parity, stop.
          shift_frame_d    = {1'b0, 1'b1, hsle_pkg::odd_count(tx_byte), tx_byte};
          bit_index_d      = 4'd1;
        end
      end
      hsle_pkg::ActReceive: begin
        if (!sending_q && !receiving_q) begin
          receiving_d   = 1'b1;
          bit_index_d   = '0;
          error_code_d  = hsle_pkg::StOk;
          ack_level_d   = 1'b0;
          shift_frame_d = '0;
          drive_level_d = 1'b0;
        end
      end
      hsle_pkg::ActTick: begin
        if (sending_q) begin
          if (bit_index_q == hsle_pkg::PosTxFinal) begin
            ack_level_d = line_in;
            bit_index_d = bit_index_q + 4'd1;
          end else if (bit_index_q <= hsle_pkg::PosTxWait && line_in) begin
            // Partner line went high during the frame: abort.
            drive_level_d = 1'b1;
            error_code_d  = hsle_pkg::StLineHigh;
            sending_d     = 1'b0;
            out_d.tx_done = 1'b1;
          end else if (bit_index_q == hsle_pkg::PosTxWait) begin
            drive_level_d = 1'b0;
            bit_index_d   = bit_index_q + 4'd1;
          end else if (bit_index_q == hsle_pkg::PosTxSwap) begin
            drive_level_d = 1'b1;
            error_code_d  = ack_level_q ? hsle_pkg::StOk : hsle_pkg::StNack;
            sending_d     = 1'b0;
            out_d.tx_done = 1'b1;
          end else begin
            drive_level_d = shift_frame_q[0];
            shift_frame_d = {1'b0, shift_frame_q[hsle_pkg::FrameW-1:1]};
            bit_index_d   = bit_index_q + 4'd1;
          end
        end else if (receiving_q) begin
          if (bit_index_q == '0) begin
            drive_level_d = 1'b0;
          end
          if (bit_index_q == hsle_pkg::PosRxAck) begin
            if (error_code_q == hsle_pkg::StOk) begin
              drive_level_d = 1'b1;
            end
            bit_index_d = bit_index_q + 4'd1;
          end else if (bit_index_q == hsle_pkg::PosRxEnd) begin
            drive_level_d = 1'b1;
            receiving_d   = 1'b0;
          end else begin
            shift_frame_d = rx_frame;
            if (bit_index_q == hsle_pkg::PosRxStop) begin
              // Start outranks parity, parity outranks stop.
              if (rx_frame[10]) begin
                error_code_d = hsle_pkg::StBadStart;
              end else if (rx_frame[1] != hsle_pkg::odd_count(rx_data)) begin
                error_code_d = hsle_pkg::StBadParity;
              end else if (!rx_frame[0]) begin
                error_code_d = hsle_pkg::StBadStop;
              end else if (error_code_q == hsle_pkg::StOk) begin
                if (rx_room) begin
                  out_d.rx_valid = 1'b1;
                end else begin
                  error_code_d = hsle_pkg::StQueueFull;
                end
              end
              out_d.rx_byte = rx_data;
            end
            bit_index_d = bit_index_q + 4'd1;
          end
        end
      end
      default: begin
        // Unused action code: no state change.
      end
    endcase

    out_d.line_out = drive_level_d;
    out_d.tx_busy  = sending_d;
    out_d.rx_busy  = receiving_d;
    out_d.status   = error_code_d;
  end

  // State registers advance on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_index_q   <= '0;
      shift_frame_q <= '0;
      error_code_q  <= hsle_pkg::StOk;
      ack_level_q   <= 1'b0;
      sending_q     <= 1'b0;
      receiving_q   <= 1'b0;
      drive_level_q <= 1'b1;
    end else if (in_xfer) begin
      bit_index_q   <= bit_index_d;
      shift_frame_q <= shift_frame_d;
      error_code_q  <= error_code_d;
      ack_level_q   <= ack_level_d;
      sending_q     <= sending_d;
      receiving_q   <= receiving_d;
      drive_level_q <= drive_level_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.rx_valid, out_q.rx_byte, out_q.status,
                            out_q.tx_done, out_q.tx_started, out_q.rx_busy,
                            out_q.tx_busy, out_q.line_out};

`ifndef NO_ASSERTIONS
  // The engine never sends and receives at once.
  a_half_duplex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sending_q && receiving_q))
    else $error("send and receive active together");

  // A good received byte always comes with an ok status.
  a_rx_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx_valid) |-> (out_q.status == hsle_pkg::StOk))
    else $error("rx_valid with a nonzero status");

  // A finished send leaves the engine idle on a high line.
  a_tx_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.tx_done) |-> (!out_q.tx_busy && out_q.line_out))
    else $error("tx_done while still busy or line low");

  // An accepted send request drives the start bit.
  a_tx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && out_d.tx_started) |=> (sending_q && !drive_level_q))
    else $error("send start not taken");
`endif

endmodule

/* tb/hsle_link_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link engine checker
// Watches both stream channels of the serial link engine. Every accepted input
// transfer is run through a cycle-free prediction of the engine's send and
// receive sequences, and every accepted output transfer is compared with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hsle_link_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [hsle_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [hsle_pkg::ActionW-1:0]  s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [hsle_pkg::OutDataW-1:0] m_tdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            tx_acked_o,
  output int                            tx_nacked_o,
  output int                            tx_aborted_o,
  output int                            rx_good_o,
  output int                            rx_rejected_o
);

  // One bit interval as it arrives on the input channel.
  typedef struct packed {
    logic [hsle_pkg::ActionW-1:0]  action;
    logic [hsle_pkg::DataBits-1:0] tx_byte;
    logic                          line_in;
    logic                          room;
  } bit_slot_t;

  // Predicted engine state.
  logic [hsle_pkg::IndexW-1:0]  pos_q    = '0;
  logic [hsle_pkg::FrameW-1:0]  frame_q  = '0;
  logic [hsle_pkg::StatusW-1:0] err_q    = hsle_pkg::StOk;
  logic                         ack_q    = 1'b0;
  logic                         tx_on_q  = 1'b0;
  logic                         rx_on_q  = 1'b0;
  logic                         drive_q  = 1'b1;

  // Line levels and status words still owed by the engine, oldest first.
  hsle_pkg::result_t awaited_q[$];

  function automatic string show(input hsle_pkg::result_t r);
    return $sformatf({"line=%0b txb=%0b rxb=%0b start=%0b done=%0b",
                      " st=%0d byte=%02h ok=%0b"},
                     r.line_out, r.tx_busy, r.rx_busy, r.tx_started, r.tx_done,
                     r.status, r.rx_byte, r.rx_valid);
  endfunction

  // Advance the link by one bit interval and form its status word.
  task automatic advance_link(input bit_slot_t it, output hsle_pkg::result_t r,
                              output bit checked);
    logic [hsle_pkg::DataBits-1:0] data;
    logic                          par;
    r       = '0;
    checked = 1'b0;
    case (it.action)
      hsle_pkg::ActSend: begin
        if (!tx_on_q && !rx_on_q && it.line_in) begin
          // Start bit goes out now; stop, parity and data wait in the shifter.
          tx_on_q      = 1'b1;
          r.tx_started = 1'b1;
          drive_q      = 1'b0;
          frame_q      = {1'b0, 1'b1, ^it.tx_byte, it.tx_byte};
          pos_q        = 4'd1;
        end
      end
      hsle_pkg::ActReceive: begin
        if (!tx_on_q && !rx_on_q) begin
          rx_on_q = 1'b1;
          pos_q   = '0;
          err_q   = hsle_pkg::StOk;
          ack_q   = 1'b0;
          frame_q = '0;
          drive_q = 1'b0;
        end
      end
      hsle_pkg::ActTick: begin
        if (tx_on_q) begin
          if (pos_q == hsle_pkg::PosTxFinal) begin
            ack_q = it.line_in;
            pos_q = pos_q + 4'd1;
          end else if (pos_q <= hsle_pkg::PosTxWait && it.line_in) begin
            // Partner did not hold its line low: give up the send.
            drive_q   = 1'b1;
            err_q     = hsle_pkg::StLineHigh;
            tx_on_q   = 1'b0;
            r.tx_done = 1'b1;
          end else if (pos_q == hsle_pkg::PosTxWait) begin
            drive_q = 1'b0;
            pos_q   = pos_q + 4'd1;
          end else if (pos_q == hsle_pkg::PosTxSwap) begin
            drive_q   = 1'b1;
            err_q     = ack_q ? hsle_pkg::StOk : hsle_pkg::StNack;
            tx_on_q   = 1'b0;
            r.tx_done = 1'b1;
          end else begin
            drive_q = frame_q[0];
            frame_q = frame_q >> 1;
            pos_q   = pos_q + 4'd1;
          end
        end else if (rx_on_q) begin
          if (pos_q == '0) drive_q = 1'b0;
          if (pos_q == hsle_pkg::PosRxAck) begin
            if (err_q == hsle_pkg::StOk) drive_q = 1'b1;
            pos_q = pos_q + 4'd1;
          end else if (pos_q == hsle_pkg::PosRxEnd) begin
            drive_q = 1'b1;
            rx_on_q = 1'b0;
          end else begin
            frame_q = {frame_q[hsle_pkg::FrameW-2:0], it.line_in};
            if (pos_q == hsle_pkg::PosRxStop) begin
              // Start bit sits on top, data arrived LSB first, stop at bit 0.
              par = frame_q[1];
              for (int i = 0; i < hsle_pkg::DataBits; i++) data[i] = frame_q[9-i];
              if (!frame_q[0]) err_q = hsle_pkg::StBadStop;
              if (par != ^data) err_q = hsle_pkg::StBadParity;
              if (frame_q[10]) err_q = hsle_pkg::StBadStart;
              if (err_q == hsle_pkg::StOk) begin
                if (it.room) r.rx_valid = 1'b1;
                else err_q = hsle_pkg::StQueueFull;
              end
              r.rx_byte = data;
              checked   = 1'b1;
            end
            pos_q = pos_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
    r.line_out = drive_q;
    r.tx_busy  = tx_on_q;
    r.rx_busy  = rx_on_q;
    r.status   = err_q;
  endtask

  // Compare results at the output, predict at the input.
  always @(posedge clk_i) begin : watch
    hsle_pkg::result_t want;
    hsle_pkg::result_t got;
    bit_slot_t         item;
    bit                checked;
    if (!rst_ni) begin
      pos_q   = '0;
      frame_q = '0;
      err_q   = hsle_pkg::StOk;
      ack_q   = 1'b0;
      tx_on_q = 1'b0;
      rx_on_q = 1'b0;
      drive_q = 1'b1;
      awaited_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.line_out   = m_tdata_i[0];
        got.tx_busy    = m_tdata_i[1];
        got.rx_busy    = m_tdata_i[2];
        got.tx_started = m_tdata_i[3];
        got.tx_done    = m_tdata_i[4];
        got.status     = m_tdata_i[7:5];
        got.rx_byte    = m_tdata_i[15:8];
        got.rx_valid   = m_tdata_i[16];
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t ns: result with nothing awaited: %s", $realtime, show(got));
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t ns: result mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        item.action  = s_tuser_i;
        item.tx_byte = s_tdata_i[7:0];
        item.line_in = s_tdata_i[8];
        item.room    = s_tdata_i[9];
        advance_link(item, want, checked);
        awaited_q.push_back(want);
        if (want.tx_done) begin
          if (want.status == hsle_pkg::StOk) tx_acked_o++;
          else if (want.status == hsle_pkg::StNack) tx_nacked_o++;
          else tx_aborted_o++;
        end
        if (checked) begin
          if (want.rx_valid) rx_good_o++;
          else rx_rejected_o++;
        end
      end
    end
    pending_o = awaited_q.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link engine testbench
// Drives bit intervals into the serial link engine: send frames with and
// without ACK or a partner that breaks in, receive frames that are clean or
// carry start, parity and stop faults, stray requests and noise. Both sides
// idle in random bursts; the checker beside the engine scores every result.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [hsle_pkg::ActionW-1:0] ActReserved = 2'd3;
  localparam int unsigned ItemsGoal  = 850;
  localparam int unsigned CalmAfter  = 720;
  localparam int unsigned PressAfter = 300;
  localparam int unsigned PressHold  = 120;

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [hsle_pkg::InDataW-1:0]  s_tdata  = '0;
  logic [hsle_pkg::ActionW-1:0]  s_tuser  = hsle_pkg::ActTick;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [hsle_pkg::OutDataW-1:0] m_tdata;

  // Receiver pacing and the single long hold-off.
  logic       calm       = 1'b0;
  logic       press_req  = 1'b0;
  logic       press_done = 1'b0;
  logic       stall_mode = 1'b0;
  int         hold_left  = 0;
  int         phase_left = 0;

  // Sender pacing and progress.
  bit         src_gappy  = 1'b0;
  int         useful_items = 0;

  int fail_count, pending, tx_acked, tx_nacked, tx_aborted, rx_good, rx_rejected;

  always #6 clk_i = ~clk_i;

  handshake_serial_link_engine_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  hsle_link_checker link_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .tx_acked_o    (tx_acked),
    .tx_nacked_o   (tx_nacked),
    .tx_aborted_o  (tx_aborted),
    .rx_good_o     (rx_good),
    .rx_rejected_o (rx_rejected)
  );

  // Random single bit and random byte.
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  // Result side: phases with and without stalls, plus one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(40, 300);
        stall_mode <= coin();
      end else begin
        phase_left <= phase_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (press_req && !press_done) begin
        hold_left  <= PressHold - 1;
        press_done <= 1'b1;
        m_tready   <= 1'b0;
      end else if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
        hold_left <= $urandom_range(0, 18);
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one bit interval and hold it until the engine takes the transfer.
  task automatic offer(input logic [hsle_pkg::ActionW-1:0] act, input logic [7:0] byte_v,
                       input logic lin, input logic room, input bit tally);
    bit took;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {6'd0, room, lin, byte_v};
    took = 1'b0;
    while (!took) begin
      @(negedge clk_i);
      took = s_tready;
      @(posedge clk_i);
    end
    if (tally) useful_items++;
    if (src_gappy && !calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // A request the busy engine must ignore.
  task automatic stray();
    case ($urandom_range(0, 2))
      0: offer(hsle_pkg::ActReceive, any_byte(), coin(), coin(), 1'b1);
      1: offer(hsle_pkg::ActSend, any_byte(), 1'b1, coin(), 1'b1);
      default: offer(ActReserved, any_byte(), coin(), coin(), 1'b1);
    endcase
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return any_byte();
    endcase
  endfunction

  // Send a byte; the partner breaks in at abort_at (1..11) or stays low.
  task automatic send_frame(input logic [7:0] byte_v, input int abort_at, input logic ack);
    int k;
    offer(hsle_pkg::ActSend, byte_v, 1'b1, coin(), 1'b1);
    for (k = 1; k <= 11; k++) begin
      if ($urandom_range(0, 29) == 0) stray();
      offer(hsle_pkg::ActTick, any_byte(), k == abort_at, coin(), 1'b1);
      if (k == abort_at) return;
    end
    offer(hsle_pkg::ActTick, any_byte(), ack, coin(), 1'b1);
    offer(hsle_pkg::ActTick, any_byte(), coin(), coin(), 1'b1);
  endtask

  // Receive a byte whose frame bits are flipped by flaw.
  task automatic recv_frame(input logic [7:0] byte_v, input logic [10:0] flaw,
                            input logic room);
    logic [10:0] frame;
    int          k;
    frame = {1'b1, ^byte_v, byte_v, 1'b0} ^ flaw;
    offer(hsle_pkg::ActReceive, any_byte(), coin(), coin(), 1'b1);
    for (k = 0; k <= 10; k++) begin
      if ($urandom_range(0, 29) == 0) stray();
      offer(hsle_pkg::ActTick, any_byte(), frame[k], (k == 10) ? room : coin(), 1'b1);
    end
    offer(hsle_pkg::ActTick, any_byte(), coin(), coin(), 1'b1);
    offer(hsle_pkg::ActTick, any_byte(), coin(), coin(), 1'b1);
  endtask

  // Random actions of any kind, then ticks that run out whatever they began.
  task automatic noise();
    logic [hsle_pkg::ActionW-1:0] act;
    bit                           began;
    began = 1'b0;
    repeat ($urandom_range(1, 4)) begin
      act = hsle_pkg::ActionW'($urandom_range(0, 3));
      if (act == hsle_pkg::ActSend || act == hsle_pkg::ActReceive) began = 1'b1;
      offer(act, any_byte(), coin(), coin(), 1'b1);
    end
    if (began) repeat (14) offer(hsle_pkg::ActTick, any_byte(), 1'b0, coin(), 1'b1);
  endtask

  function automatic logic [10:0] pick_flaw();
    case ($urandom_range(0, 9))
      0: return 11'h001;
      1: return 11'h200;
      2: return 11'h400;
      3: return 11'($urandom);
      4: return 11'h001 << $urandom_range(1, 8);
      default: return 11'h000;
    endcase
  endfunction

  initial begin : stimulus
    bit press_sent;
    int pick;
    int waited;
    press_sent = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick, reserved action, send refused on a low line,
    // an acked all-ones send with ignored requests inside, an early abort.
    offer(hsle_pkg::ActTick, 8'h00, 1'b0, 1'b0, 1'b1);
    offer(ActReserved, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(hsle_pkg::ActSend, 8'hFF, 1'b0, 1'b1, 1'b1);
    offer(hsle_pkg::ActSend, 8'hFF, 1'b1, 1'b1, 1'b1);
    offer(hsle_pkg::ActTick, 8'h00, 1'b0, 1'b0, 1'b1);
    offer(hsle_pkg::ActReceive, 8'h00, 1'b1, 1'b1, 1'b1);
    offer(ActReserved, 8'h00, 1'b0, 1'b0, 1'b1);
    repeat (10) offer(hsle_pkg::ActTick, 8'hFF, 1'b0, 1'b1, 1'b1);
    offer(hsle_pkg::ActTick, 8'h00, 1'b1, 1'b0, 1'b1);
    offer(hsle_pkg::ActTick, 8'h00, 1'b0, 1'b0, 1'b1);
    send_frame(8'h00, 1, 1'b1);

    // Random: mostly well-formed frames with random content.
    while (useful_items < ItemsGoal) begin
      src_gappy = $urandom_range(0, 2) != 0;
      if (!press_sent && useful_items > PressAfter) begin
        press_req  <= 1'b1;
        press_sent = 1'b1;
      end
      if (useful_items > CalmAfter) calm <= 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_frame(pick_byte(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0,
                   $urandom_range(0, 3) != 0);
      else if (pick < 8)
        recv_frame(pick_byte(), pick_flaw(), $urandom_range(0, 3) != 0);
      else
        noise();
    end
    s_tvalid <= 1'b0;

    // Drain the outstanding results, then let the pipeline settle.
    waited = 0;
    do begin
      @(negedge clk_i);
      waited++;
    end while (pending != 0 && waited < 5000);
    repeat (8) @(posedge clk_i);

    $display("Sends: %0d acked, %0d nacked, %0d broken off; receives: %0d good, %0d rejected.",
             tx_acked, tx_nacked, tx_aborted, rx_good, rx_rejected);
    $display("Mismatches: %0d, results never delivered: %0d.", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
